// File: sv/snt_pkg.sv
// Sensor node table: shared word, entry, state and command types.
package snt_pkg;

  typedef struct packed {
    logic              operation;
    logic [7:0]        node_address;
    logic [15:0]       temp_one;
    logic [15:0]       temp_two;
    logic [15:0]       battery;
    logic signed [7:0] signal_strength;
    logic [15:0]       elapsed_seconds;
  } snt_in_t;

  typedef struct packed {
    logic [2:0]        slot_index;
    logic              slot_valid;
    logic [7:0]        slot_address;
    logic [15:0]       slot_temp_one;
    logic [15:0]       slot_temp_two;
    logic [15:0]       slot_battery;
    logic signed [7:0] slot_signal;
    logic [31:0]       slot_age;
    logic [31:0]       slot_packets;
    logic [31:0]       uptime;
    logic              last;
  } snt_out_t;

  typedef struct packed {
    logic [7:0]        address;
    logic [15:0]       temp_one;
    logic [15:0]       temp_two;
    logic [15:0]       battery;
    logic signed [7:0] signal;
    logic [31:0]       age;
    logic [31:0]       packets;
  } snt_entry_t;

  localparam int unsigned EntryW = $bits(snt_entry_t);

  localparam logic OpPacket = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } snt_state_e;

  typedef struct packed {
    logic start;       // latch the input word, read slot 0
    logic advance;     // step to the next slot, read it
    logic wr_update;   // rewrite the matching entry
    logic wr_insert;   // write a new entry at the insert pointer
    logic out_load;    // load the report word, write back the age
    logic uptime_add;  // end of report run
  } snt_cmd_t;

  typedef struct packed {
    logic in_tick;
    logic in_addr_zero;
    logic match;
    logic slot_last;
    logic out_free;
  } snt_status_t;

endpackage

// File: sv/sensor_node_table.sv
// Sensor node table: top level joining the controller and the datapath.
//
//  channel  direction  word       handshake
//  in       input      snt_in_t   in_valid_i / in_stall_o
//  out      output     snt_out_t  out_valid_o / out_stall_i
//
// Packet word: accepted, then one slot searched per cycle until a match or
// the last slot; a packet from address zero is taken and dropped unsearched.
// Tick word: a report word per slot, one per cycle unless output is stalled.
// Both rates are set by the single read port of the entry RAM.
// Reset empties every slot and clears the insert pointer and the uptime.
// Output stall holds the report run on its current slot; input is stalled
// until the packet or the whole run is done.
module sensor_node_table #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  snt_pkg::snt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output snt_pkg::snt_out_t out_data_o
);
  import snt_pkg::*;

  snt_cmd_t    cmd;
  snt_status_t status;

  snt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  snt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/snt_ram.sv
// Sensor node table: generic simple dual-port RAM with registered read.
module snt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/snt_ctrl.sv
// Sensor node table: sequencing state machine for packet scan and report run.
module snt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  snt_pkg::snt_status_t status_i,
  output snt_pkg::snt_cmd_t    cmd_o
);
  import snt_pkg::*;

  snt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        // packets from address zero are taken and dropped
        if (in_valid_i && (status_i.in_tick || !status_i.in_addr_zero)) begin
          cmd_o.start = 1'b1;
          state_d     = status_i.in_tick ? ST_REPORT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.match) begin
          cmd_o.wr_update = 1'b1;
          state_d         = ST_IDLE;
        end else if (status_i.slot_last) begin
          cmd_o.wr_insert = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_REPORT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.slot_last) begin
            cmd_o.uptime_add = 1'b1;
            state_d          = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/snt_dp.sv
// Sensor node table: entry store, valid bits, pointers, uptime and output word.
module snt_dp #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  snt_pkg::snt_in_t     in_data_i,
  input  snt_pkg::snt_cmd_t    cmd_i,
  output snt_pkg::snt_status_t status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output snt_pkg::snt_out_t    out_data_o
);
  import snt_pkg::*;

  localparam int unsigned SlotW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_ENTRIES - 1);

  snt_in_t                  in_q;
  logic [SlotW-1:0]         slot_q, slot_d;
  logic [SlotW-1:0]         ptr_q, ptr_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [31:0]              uptime_q, uptime_d;
  logic                     out_valid_q, out_valid_d;
  snt_out_t                 out_q, out_d;

  logic                     wr_en;
  logic [SlotW-1:0]         wr_addr;
  snt_entry_t               wr_data;
  logic                     rd_en;
  logic [SlotW-1:0]         rd_addr;
  snt_entry_t               rd_data;
  logic                     cur_valid;
  logic [31:0]              age_sum;

  snt_ram #(
    .Width (EntryW),
    .Depth (TABLE_ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign cur_valid = valid_q[slot_q];
  assign age_sum   = rd_data.age + 32'(in_q.elapsed_seconds);

  assign rd_en   = cmd_i.start | cmd_i.advance;
  assign rd_addr = cmd_i.start ? '0 : slot_q + SlotW'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_q;
    wr_data = rd_data;
    if (cmd_i.wr_update) begin
      wr_en            = 1'b1;
      wr_data.temp_one = in_q.temp_one;
      wr_data.temp_two = in_q.temp_two;
      wr_data.battery  = in_q.battery;
      wr_data.signal   = in_q.signal_strength;
      wr_data.age      = '0;
      wr_data.packets  = rd_data.packets + 32'd1;
    end
    if (cmd_i.wr_insert) begin
      wr_en            = 1'b1;
      wr_addr          = ptr_q;
      wr_data.address  = in_q.node_address;
      wr_data.temp_one = in_q.temp_one;
      wr_data.temp_two = in_q.temp_two;
      wr_data.battery  = in_q.battery;
      wr_data.signal   = in_q.signal_strength;
      wr_data.age      = '0;
      wr_data.packets  = 32'd1;
    end
    if (cmd_i.out_load && cur_valid) begin
      wr_en       = 1'b1;
      wr_data.age = age_sum;
    end
  end

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.start) begin
      slot_d = '0;
    end else if (cmd_i.advance) begin
      slot_d = slot_q + SlotW'(1);
    end
  end

  always_comb begin
    ptr_d   = ptr_q;
    valid_d = valid_q;
    if (cmd_i.wr_insert) begin
      ptr_d          = (ptr_q == LastSlot) ? '0 : ptr_q + SlotW'(1);
      valid_d[ptr_q] = 1'b1;
    end
  end

  assign uptime_d = cmd_i.uptime_add ? uptime_q + 32'(in_q.elapsed_seconds) : uptime_q;

  always_comb begin
    out_d = out_q;
    if (cmd_i.out_load) begin
      out_d.slot_index    = 3'(slot_q);
      out_d.slot_valid    = cur_valid;
      out_d.slot_address  = cur_valid ? rd_data.address  : '0;
      out_d.slot_temp_one = cur_valid ? rd_data.temp_one : '0;
      out_d.slot_temp_two = cur_valid ? rd_data.temp_two : '0;
      out_d.slot_battery  = cur_valid ? rd_data.battery  : '0;
      out_d.slot_signal   = cur_valid ? rd_data.signal   : '0;
      out_d.slot_age      = cur_valid ? age_sum          : '0;
      out_d.slot_packets  = cur_valid ? rd_data.packets  : '0;
      out_d.uptime        = uptime_q;
      out_d.last          = (slot_q == LastSlot);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      ptr_q       <= '0;
      valid_q     <= '0;
      uptime_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      ptr_q       <= ptr_d;
      valid_q     <= valid_d;
      uptime_q    <= uptime_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      in_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign status_o.in_tick      = (in_data_i.operation == OpTick);
  assign status_o.in_addr_zero = (in_data_i.node_address == 8'd0);
  assign status_o.match        = cur_valid && (rd_data.address == in_q.node_address);
  assign status_o.slot_last    = (slot_q == LastSlot);
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/snt_checker.sv
// Sensor node table: port-level checker and its bind to the top level.
module snt_checker #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input snt_pkg::snt_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.slot_index == 3'(TABLE_ENTRIES - 1))
    else $error("last flag on wrong slot");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.slot_valid |->
      out_data_o.slot_address == 8'd0 && out_data_o.slot_age == 32'd0 &&
      out_data_o.slot_packets == 32'd0)
    else $error("empty slot reported with data");

  a_valid_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.slot_valid |-> out_data_o.slot_address != 8'd0)
    else $error("valid slot with address zero");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken during a report run");

endmodule

bind sensor_node_table snt_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_snt_checker (.*);

// File: verif/sensor_node_table_chk.sv
// Sensor node table checker: watches both channels, predicts report words and compares them.
module sensor_node_table_chk #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  snt_pkg::snt_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  snt_pkg::snt_out_t out_data_i,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import snt_pkg::*;

  snt_entry_t  node_tab [TABLE_ENTRIES];
  int unsigned ins_ptr;
  logic [31:0] uptime_s;
  snt_out_t    report_q [$];
  int unsigned errs;
  int unsigned checked;

  initial begin
    errs    = 0;
    checked = 0;
  end

  task automatic note_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errs++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic clear_table();
    for (int s = 0; s < TABLE_ENTRIES; s++) node_tab[s] = '0;
    ins_ptr  = 0;
    uptime_s = '0;
    report_q.delete();
  endtask

  // Packets update or insert; a tick ages valid slots and queues one report word per slot.
  task automatic absorb_word(input snt_in_t w);
    int       idx;
    bit       hit;
    snt_out_t rep;
    hit = 0;
    idx = 0;
    if (w.operation == OpPacket) begin
      if (w.node_address != 8'd0) begin
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
          if (!hit && node_tab[s].address == w.node_address) begin
            hit = 1;
            idx = s;
          end
        end
        if (hit) begin
          node_tab[idx].packets = node_tab[idx].packets + 32'd1;
        end else begin
          idx = ins_ptr;
          node_tab[idx].address = w.node_address;
          node_tab[idx].packets = 32'd1;
          ins_ptr = (ins_ptr + 1 >= TABLE_ENTRIES) ? 0 : ins_ptr + 1;
        end
        node_tab[idx].temp_one = w.temp_one;
        node_tab[idx].temp_two = w.temp_two;
        node_tab[idx].battery  = w.battery;
        node_tab[idx].signal   = w.signal_strength;
        node_tab[idx].age      = '0;
      end
    end else begin
      for (int s = 0; s < TABLE_ENTRIES; s++) begin
        rep = '0;
        rep.slot_index = 3'(s);
        if (node_tab[s].address != 8'd0) begin
          node_tab[s].age   = node_tab[s].age + {16'd0, w.elapsed_seconds};
          rep.slot_valid    = 1'b1;
          rep.slot_address  = node_tab[s].address;
          rep.slot_temp_one = node_tab[s].temp_one;
          rep.slot_temp_two = node_tab[s].temp_two;
          rep.slot_battery  = node_tab[s].battery;
          rep.slot_signal   = node_tab[s].signal;
          rep.slot_age      = node_tab[s].age;
          rep.slot_packets  = node_tab[s].packets;
        end
        rep.uptime = uptime_s;
        rep.last   = (s + 1 == TABLE_ENTRIES);
        report_q.push_back(rep);
      end
      uptime_s = uptime_s + {16'd0, w.elapsed_seconds};
    end
  endtask

  task automatic compare_report(input snt_out_t got);
    snt_out_t want;
    if (report_q.size() == 0) begin
      note_mismatch("report word with none expected");
      return;
    end
    want = report_q.pop_front();
    checked++;
    check_field("slot_index",    32'(got.slot_index),    32'(want.slot_index));
    check_field("slot_valid",    32'(got.slot_valid),    32'(want.slot_valid));
    check_field("slot_address",  32'(got.slot_address),  32'(want.slot_address));
    check_field("slot_temp_one", 32'(got.slot_temp_one), 32'(want.slot_temp_one));
    check_field("slot_temp_two", 32'(got.slot_temp_two), 32'(want.slot_temp_two));
    check_field("slot_battery",  32'(got.slot_battery),  32'(want.slot_battery));
    check_field("slot_signal",   32'($unsigned(got.slot_signal)),
                32'($unsigned(want.slot_signal)));
    check_field("slot_age",      got.slot_age,           want.slot_age);
    check_field("slot_packets",  got.slot_packets,       want.slot_packets);
    check_field("uptime",        got.uptime,             want.uptime);
    check_field("last",          32'(got.last),          32'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
    end else begin
      if (in_valid_i && !in_stall_i) absorb_word(in_data_i);
      if (out_valid_i && !out_stall_i) compare_report(out_data_i);
    end
    mismatch_cnt_o <= errs;
    pending_o      <= report_q.size();
    checked_o      <= checked;
  end

endmodule

// File: verif/sensor_node_table_tb.sv
// Sensor node table testbench top: clock, reset, stimulus, stalls and verdict.
module sensor_node_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import snt_pkg::*;

  localparam int unsigned Slots = 8;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  snt_in_t     in_data_i   = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  snt_out_t    out_data_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned words_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned zero_sent  = 0;

  sensor_node_table #(.TABLE_ENTRIES(Slots)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  sensor_node_table_chk #(.TABLE_ENTRIES(Slots)) u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_i     (out_data_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt),
    .checked_o      (checked_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic snt_in_t mk_word(input logic op, input logic [7:0] addr,
                                      input logic [15:0] t1, input logic [15:0] t2,
                                      input logic [15:0] bat, input logic [7:0] sig,
                                      input logic [15:0] el);
    snt_in_t w;
    w.operation       = op;
    w.node_address    = addr;
    w.temp_one        = t1;
    w.temp_two        = t2;
    w.battery         = bat;
    w.signal_strength = sig;
    w.elapsed_seconds = el;
    return w;
  endfunction

  task automatic push_word(input snt_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    words_sent++;
    if (w.operation == OpTick) ticks_sent++;
    else if (w.node_address == 8'd0) zero_sent++;
  endtask

  // Mostly packets from a small address pool so updates hit, plus ticks and
  // stray addresses that force round-robin replacement.
  task automatic random_words(input int unsigned n);
    snt_in_t     w;
    int unsigned r;
    int unsigned done_n;
    done_n = 0;
    while (done_n < n) begin
      w.temp_one        = 16'($urandom);
      w.temp_two        = 16'($urandom);
      w.battery         = 16'($urandom);
      w.signal_strength = 8'($urandom);
      w.elapsed_seconds = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
      w.node_address    = 8'($urandom);
      r = $urandom_range(99);
      if (r < 22) begin
        w.operation = OpTick;
      end else begin
        w.operation = OpPacket;
        if (r < 27) w.node_address = 8'd0;
        else if (r < 50) w.node_address = 8'($urandom_range(255, 1));
        else w.node_address = 8'($urandom_range(12, 1));
      end
      push_word(w);
      if (!(w.operation == OpPacket && w.node_address == 8'd0)) done_n++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni         <= 1'b1;
    send_idle_pct  <= 13;
    recv_stall_pct <= 55;
    @(posedge clk_i);

    // empty table report, address zero ignored, extremes, update, fill and wrap
    push_word(mk_word(OpTick,   8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h7F, 16'd5));
    push_word(mk_word(OpPacket, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h7F, 16'hFFFF));
    push_word(mk_word(OpPacket, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h7F, 16'h0000));
    push_word(mk_word(OpPacket, 8'h01, 16'h0000, 16'h0000, 16'h0000, 8'h80, 16'hFFFF));
    push_word(mk_word(OpTick,   8'hFF, 16'h0000, 16'h0000, 16'h0000, 8'h80, 16'hFFFF));
    push_word(mk_word(OpPacket, 8'hFF, 16'h1234, 16'h5678, 16'h9ABC, 8'hC4, 16'h0000));
    push_word(mk_word(OpTick,   8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000));
    for (int a = 2; a < Slots; a++) begin
      push_word(mk_word(OpPacket, 8'(a), 16'(a * 257), 16'(a * 1031), 16'(3000 + a),
                        8'(-a), 16'(a)));
    end
    push_word(mk_word(OpPacket, 8'h09, 16'h0A80, 16'h0B40, 16'h0C00, 8'hD8, 16'h0000));
    push_word(mk_word(OpPacket, 8'h00, 16'h1111, 16'h2222, 16'h3333, 8'h44, 16'h5555));
    push_word(mk_word(OpTick,   8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'hFFFF));
    push_word(mk_word(OpPacket, 8'h01, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h7F, 16'h0000));
    push_word(mk_word(OpPacket, 8'h0A, 16'h0001, 16'h0002, 16'h0003, 8'h01, 16'h0000));
    push_word(mk_word(OpTick,   8'h55, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55, 16'd1));

    random_words(67);
    send_idle_pct  <= 55;
    recv_stall_pct <= 13;
    random_words(67);
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    random_words(66);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (Slots + 8) @(posedge clk_i);

    $display("run: %0d words sent, %0d report ticks, %0d packets from address zero",
             words_sent, ticks_sent, zero_sent);
    $display("run: %0d report words checked over three stall phases", checked_cnt);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/snt_pkg.sv
sv/snt_ram.sv
sv/snt_ctrl.sv
sv/snt_dp.sv
sv/sensor_node_table.sv
sv/snt_checker.sv
verif/sensor_node_table_chk.sv
verif/sensor_node_table_tb.sv
